>>> rtl/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg: shared types and constants for the factorial residue sieve
// Payload structs, opcodes, register indexes and default parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

	localparam int MAX_PRIMES_DEF = 64;
	localparam int PRIME_BITS_DEF = 63;
	localparam int N_W            = 61;
	localparam int FIELD_P_W      = 63;
	localparam int PASS_W         = 7;
	localparam int CFG_IDX_W      = 2;
	localparam logic [6:0] PRIMES_IN_USE_RST = 7'd50;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_START_N       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_N         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIMES_IN_USE = 2'd2;

	typedef struct packed {
		logic                 op;
		logic [5:0]           entry_index;
		logic [FIELD_P_W-1:0] prime_value;
		logic [FIELD_P_W-1:0] initial_residue;
	} in_item_t;

	typedef struct packed {
		logic [N_W-1:0]    tested_n;
		logic [PASS_W-1:0] tests_passed;
		logic              candidate;
		logic              range_end;
	} out_item_t;

	typedef struct packed {
		logic cap_in;
		logic ld_div_init;
		logic ld_write;
		logic step_start;
		logic mem_rd;
		logic n_div_init;
		logic div_step;
		logic mul_init;
		logic mul_dbl;
		logic mul_add;
		logic upd_write;
		logic jac_init;
		logic jac_step;
		logic jac_end;
		logic out_load;
	} frs_cmd_t;

	typedef struct packed {
		logic op;
		logic past_end;
		logic do_test;
		logic jac_quick;
		logic jac_done;
		logic out_free;
	} frs_status_t;

endpackage

`default_nettype wire

>>> rtl/frs_dp.sv
// ----------------------------------------------------------------------------
// frs_dp: datapath of the factorial residue sieve
// Entry tables, config registers, shared restoring-mod, mod-multiply and
// binary Jacobi registers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_dp import frs_pkg::*; #(
	parameter int MAX_PRIMES = MAX_PRIMES_DEF,
	parameter int PRIME_BITS = PRIME_BITS_DEF,
	localparam int AW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [N_W-1:0]       cfg_data,
	input  wire in_item_t             in_data,
	input  wire frs_cmd_t             cmd,
	input  wire logic [AW-1:0]        idx,
	output frs_status_t               status,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data
);

	localparam int PW  = PRIME_BITS;
	localparam int DW  = (PW > N_W) ? PW : N_W;
	localparam int PCW = $clog2(MAX_PRIMES + 1);

	logic [2*PW-1:0] mem [MAX_PRIMES];

	logic [N_W-1:0] start_q, end_q, n_q;
	logic [6:0]     piu_q;
	logic           op_q;
	logic [5:0]     eidx_q;
	logic [PW-1:0]  pin_q, res_q;
	logic [PW-1:0]  p_q, f_q, y_q, a_q, b_q;
	logic [PW:0]    r_q;
	logic [DW-1:0]  d_q;
	logic           j_q;
	logic [PCW-1:0] passed_q;
	logic           failed_q;
	logic           ovalid_q;
	out_item_t      out_q;

	logic [PW:0]   div_s, dbl_s, add_s;
	logic [PW-1:0] newf, a_init;
	logic          jac_bad, a_lt;

	always_comb begin
		div_s  = {r_q[PW-1:0], d_q[DW-1]};
		dbl_s  = {r_q[PW-1:0], 1'b0};
		add_s  = r_q + {1'b0, f_q};
		newf   = (p_q == '0) ? '0 : r_q[PW-1:0];
		a_init = f_q + PW'(1);
		jac_bad = (p_q < PW'(3)) || !p_q[0];
		a_lt   = a_q < b_q;
	end

	assign status.op        = op_q;
	assign status.past_end  = n_q >= end_q;
	assign status.do_test   = (int'(idx) < int'(piu_q)) && !failed_q;
	assign status.jac_quick = jac_bad || (a_init == p_q);
	assign status.jac_done  = a_q == '0;
	assign status.out_free  = !ovalid_q || !out_stall;

	assign out_valid = ovalid_q;
	assign out_data  = out_q;

	// tables: no reset, registered read
	always_ff @(posedge clk) begin
		if (cmd.ld_write && (int'(eidx_q) < MAX_PRIMES)) begin
			mem[AW'(eidx_q)] <= {pin_q, (pin_q == '0) ? {PW{1'b0}} : r_q[PW-1:0]};
		end else if (cmd.upd_write) begin
			mem[idx] <= {p_q, newf};
		end
		if (cmd.mem_rd) begin
			{p_q, f_q} <= mem[idx];
		end else begin
			if (cmd.ld_div_init) begin
				p_q <= pin_q;
			end
			if (cmd.upd_write) begin
				f_q <= newf;
			end
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q   <= in_data.op;
			eidx_q <= in_data.entry_index;
			pin_q  <= PW'(in_data.prime_value);
			res_q  <= PW'(in_data.initial_residue);
		end
		if (cmd.ld_div_init) begin
			d_q <= DW'(res_q);
			r_q <= '0;
		end else if (cmd.n_div_init) begin
			d_q <= DW'(n_q);
			r_q <= '0;
		end else if (cmd.div_step) begin
			d_q <= d_q << 1;
			r_q <= (div_s >= {1'b0, p_q}) ? div_s - {1'b0, p_q} : div_s;
		end else if (cmd.mul_init) begin
			y_q <= r_q[PW-1:0];
			r_q <= '0;
		end else if (cmd.mul_dbl) begin
			r_q <= (dbl_s >= {1'b0, p_q}) ? dbl_s - {1'b0, p_q} : dbl_s;
		end else if (cmd.mul_add) begin
			y_q <= y_q << 1;
			if (y_q[PW-1]) begin
				r_q <= (add_s >= {1'b0, p_q}) ? add_s - {1'b0, p_q} : add_s;
			end
		end
		if (cmd.jac_init) begin
			a_q <= a_init;
			b_q <= p_q;
			j_q <= 1'b1;
		end else if (cmd.jac_step) begin
			if (!a_q[0]) begin
				a_q <= a_q >> 1;
				if (b_q[2:0] == 3'd3 || b_q[2:0] == 3'd5) begin
					j_q <= !j_q;
				end
			end else if (a_lt) begin
				// swap, then subtract
				a_q <= b_q - a_q;
				b_q <= a_q;
				if (a_q[1:0] == 2'd3 && b_q[1:0] == 2'd3) begin
					j_q <= !j_q;
				end
			end else begin
				a_q <= a_q - b_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= N_W'(1);
			end_q    <= N_W'(1);
			piu_q    <= PRIMES_IN_USE_RST;
			n_q      <= '0;
			passed_q <= '0;
			failed_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_START_N:       start_q <= cfg_data;
					CFG_END_N:         end_q   <= cfg_data;
					CFG_PRIMES_IN_USE: piu_q   <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (cmd.ld_write) begin
				n_q <= start_q - N_W'(1);
			end else if (cmd.step_start) begin
				n_q <= n_q + N_W'(1);
			end
			if (cmd.step_start) begin
				passed_q <= '0;
				failed_q <= 1'b0;
			end else if (cmd.jac_init) begin
				if (jac_bad) begin
					failed_q <= 1'b1;
				end else if (a_init == p_q) begin
					passed_q <= passed_q + PCW'(1);
				end
			end else if (cmd.jac_end) begin
				if (b_q == PW'(1) && j_q) begin
					passed_q <= passed_q + PCW'(1);
				end else begin
					failed_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.tested_n     <= n_q;
			out_q.tests_passed <= PASS_W'(passed_q);
			out_q.candidate    <= !failed_q;
			out_q.range_end    <= n_q == end_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/frs_ctrl.sv
// ----------------------------------------------------------------------------
// frs_ctrl: sequencer of the factorial residue sieve
// Walks loads and steps through the datapath one bit or step at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_ctrl import frs_pkg::*; #(
	parameter int MAX_PRIMES = MAX_PRIMES_DEF,
	parameter int PRIME_BITS = PRIME_BITS_DEF,
	localparam int AW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire frs_status_t status,
	output frs_cmd_t         cmd,
	output logic [AW-1:0]    idx
);

	localparam int DW = (PRIME_BITS > N_W) ? PRIME_BITS : N_W;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_LD_DIV, S_LD_WR, S_RD, S_NDIV_INIT, S_NDIV,
		S_MUL_INIT, S_MUL_DBL, S_MUL_ADD, S_UPD, S_JAC_INIT, S_JAC, S_NEXT, S_FIN
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;

	assign in_stall = state_q != S_IDLE;
	assign idx      = idx_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:      cmd.cap_in      = in_valid;
			S_DISP: begin
				cmd.ld_div_init = status.op == OP_LOAD;
				cmd.step_start  = status.op == OP_STEP && !status.past_end;
			end
			S_LD_DIV:    cmd.div_step    = 1'b1;
			S_LD_WR:     cmd.ld_write    = 1'b1;
			S_RD:        cmd.mem_rd      = 1'b1;
			S_NDIV_INIT: cmd.n_div_init  = 1'b1;
			S_NDIV:      cmd.div_step    = 1'b1;
			S_MUL_INIT:  cmd.mul_init    = 1'b1;
			S_MUL_DBL:   cmd.mul_dbl     = 1'b1;
			S_MUL_ADD:   cmd.mul_add     = 1'b1;
			S_UPD:       cmd.upd_write   = 1'b1;
			S_JAC_INIT:  cmd.jac_init    = 1'b1;
			S_JAC: begin
				cmd.jac_step = !status.jac_done;
				cmd.jac_end  = status.jac_done;
			end
			S_NEXT:      ;
			S_FIN:       cmd.out_load    = status.out_free;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISP;
				end
				S_DISP: begin
					cnt_q <= CW'(DW);
					idx_q <= '0;
					if (status.op == OP_LOAD) state_q <= S_LD_DIV;
					else if (status.past_end) state_q <= S_IDLE;
					else state_q <= S_RD;
				end
				S_LD_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) state_q <= S_LD_WR;
				end
				S_LD_WR:     state_q <= S_IDLE;
				S_RD:        state_q <= S_NDIV_INIT;
				S_NDIV_INIT: begin
					cnt_q   <= CW'(DW);
					state_q <= S_NDIV;
				end
				S_NDIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) state_q <= S_MUL_INIT;
				end
				S_MUL_INIT: begin
					cnt_q   <= CW'(PRIME_BITS);
					state_q <= S_MUL_DBL;
				end
				S_MUL_DBL:   state_q <= S_MUL_ADD;
				S_MUL_ADD: begin
					cnt_q <= cnt_q - CW'(1);
					state_q <= (cnt_q == CW'(1)) ? S_UPD : S_MUL_DBL;
				end
				S_UPD:       state_q <= status.do_test ? S_JAC_INIT : S_NEXT;
				S_JAC_INIT:  state_q <= status.jac_quick ? S_NEXT : S_JAC;
				S_JAC: begin
					if (status.jac_done) state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (int'(idx_q) == MAX_PRIMES - 1) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default:     state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/factorial_residue_sieve.sv
// Load transaction: captures the item, reduces the initial residue in the bit-serial mod unit, then writes the entry.
// Step transaction: for each entry, reads it, reduces n mod p, multiplies it in and writes it back,
// then runs the Jacobi test on entries in use until one fails; one transaction at a time on the shared unit.
// A step past end_n returns to idle with no result.
// Reset clears control and the counter and sets config registers to defaults; entry tables stay undefined.
// ----------------------------------------------------------------------------
// factorial_residue_sieve: top level
// Joins the sequencer and the datapath of the n!+1 quadratic residue sieve.
// ----------------------------------------------------------------------------
`default_nettype none

module factorial_residue_sieve import frs_pkg::*; #(
	parameter int MAX_PRIMES = MAX_PRIMES_DEF,
	parameter int PRIME_BITS = PRIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [N_W-1:0]       cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data
);

	localparam int AW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

	frs_cmd_t      cmd;
	frs_status_t   status;
	logic [AW-1:0] idx;

	frs_ctrl #(.MAX_PRIMES(MAX_PRIMES), .PRIME_BITS(PRIME_BITS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .status, .cmd, .idx
	);

	frs_dp #(.MAX_PRIMES(MAX_PRIMES), .PRIME_BITS(PRIME_BITS)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_data, .cmd, .idx,
		.status, .out_valid, .out_stall, .out_data
	);

endmodule

`default_nettype wire

>>> verif/tb_factorial_residue_sieve.sv
// ----------------------------------------------------------------------------
// tb_factorial_residue_sieve: self-checking testbench for the sieve
// Fills the entry table, then runs directed and random load/step traffic
// under several register settings with random stalls on both channels. A
// scoreboard predicts each step result and checks every output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_factorial_residue_sieve;
	import frs_pkg::*;

	localparam int          HALF       = 6;
	localparam longint      CYCLE_CAP  = 8000000;
	localparam int          DRAIN_WAIT = 200;
	localparam int          HOLD_LEN   = 50000;
	localparam logic [60:0] N_MAX      = 61'd1152921504606846976;
	localparam logic [62:0] BIG_PRIME  = 63'd9223372036854775783;
	localparam logic [62:0] M61_PRIME  = 63'd2305843009213693951;
	localparam longint unsigned SMALL_P [16] = '{3, 5, 7, 11, 13, 17, 19, 23,
		29, 31, 37, 41, 43, 47, 53, 59};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [60:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;

	bit     quiet;
	bit     hold_req;
	bit     hold_done;
	int     hold_left;
	longint cycles;

	always #HALF clk = ~clk;

	factorial_residue_sieve u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// for an odd p of at least 3: true when a is p, or when Jacobi(a/p) is +1
	function automatic bit residue_ok(logic [63:0] a, logic [63:0] p);
		int          j;
		logic [63:0] t;
		j = 1;
		if (p < 3 || p[0] == 1'b0) return 1'b0;
		if (a == p) return 1'b1;
		a = a % p;
		while (a != 0) begin
			while (a[0] == 1'b0) begin
				a = a >> 1;
				if (p[2:0] == 3'd3 || p[2:0] == 3'd5) j = -j;
			end
			t = a;
			a = p;
			p = t;
			if (a[1:0] == 2'd3 && p[1:0] == 2'd3) j = -j;
			a = a % p;
		end
		return (p == 1 && j == 1);
	endfunction

	class sieve_scoreboard;
		logic [62:0] modulus [64];
		logic [62:0] fact [64];
		logic [60:0] start_n, end_n, cur_n;
		logic [6:0]  in_use;
		out_item_t   expected_q [$];
		int          errors;

		function new();
			start_n = 61'd1;
			end_n   = 61'd1;
			in_use  = PRIMES_IN_USE_RST;
			cur_n   = '0;
			errors  = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [60:0] v);
			case (idx)
				CFG_START_N:       start_n = v;
				CFG_END_N:         end_n   = v;
				CFG_PRIMES_IN_USE: in_use  = v[6:0];
				default: ;
			endcase
		endfunction

		function void note_input(in_item_t it);
			logic [63:0]  n, p, cnt, passed;
			logic [127:0] prod;
			bit           failed;
			out_item_t    res;
			if (it.op == OP_LOAD) begin
				modulus[it.entry_index] = it.prime_value;
				fact[it.entry_index] = (it.prime_value == 0) ? '0 :
					it.initial_residue % it.prime_value;
				cur_n = start_n - 61'd1;
				return;
			end
			if (cur_n >= end_n) return;
			n = 64'(cur_n) + 64'd1;
			cur_n = n[60:0];
			for (int i = 0; i < 64; i++) begin
				p = 64'(modulus[i]);
				if (p == 0) fact[i] = '0;
				else begin
					prod = 128'(fact[i]) * 128'(n % p);
					fact[i] = 63'(prod % 128'(p));
				end
			end
			cnt = (in_use < 7'd64) ? 64'(in_use) : 64'd64;
			passed = 0;
			failed = 1'b0;
			for (int i = 0; i < cnt && !failed; i++) begin
				if (residue_ok(64'(fact[i]) + 64'd1, 64'(modulus[i]))) passed++;
				else failed = 1'b1;
			end
			res.tested_n     = n[60:0];
			res.tests_passed = passed[6:0];
			res.candidate    = !failed;
			res.range_end    = (n[60:0] == end_n);
			expected_q.push_back(res);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result transaction %p", $time, got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.tested_n !== exp_r.tested_n) begin
				$display("%0t: tested_n expected %0d actual %0d", $time,
					exp_r.tested_n, got.tested_n);
				errors++;
			end
			if (got.tests_passed !== exp_r.tests_passed) begin
				$display("%0t: tests_passed expected %0d actual %0d (n=%0d)", $time,
					exp_r.tests_passed, got.tests_passed, exp_r.tested_n);
				errors++;
			end
			if (got.candidate !== exp_r.candidate) begin
				$display("%0t: candidate expected %0b actual %0b (n=%0d)", $time,
					exp_r.candidate, got.candidate, exp_r.tested_n);
				errors++;
			end
			if (got.range_end !== exp_r.range_end) begin
				$display("%0t: range_end expected %0b actual %0b (n=%0d)", $time,
					exp_r.range_end, got.range_end, exp_r.tested_n);
				errors++;
			end
		endfunction
	endclass

	sieve_scoreboard sb = new();

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_input(in_data);
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout, %0d results outstanding", $time,
				sb.expected_q.size());
			$display("** factorial_residue_sieve: FAILED **");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 36);
		end
	end

	task automatic send(in_item_t it);
		if (!quiet && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic load(logic [5:0] idx, logic [62:0] p, logic [62:0] r);
		in_item_t it;
		it.op              = OP_LOAD;
		it.entry_index     = idx;
		it.prime_value     = p;
		it.initial_residue = r;
		send(it);
	endtask

	task automatic step_n();
		in_item_t it;
		it.op              = OP_STEP;
		it.entry_index     = 6'($urandom);
		it.prime_value     = 63'({$urandom, $urandom});
		it.initial_residue = 63'({$urandom, $urandom});
		send(it);
	endtask

	// drop valid, wait for all results, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [60:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [62:0] pick_modulus();
		case ($urandom_range(9))
			0: return 63'({$urandom, $urandom} | 64'd1);
			1: return 63'({$urandom, $urandom} & ~64'd1);
			2: return 63'($urandom_range(2));
			3: return BIG_PRIME;
			4: return M61_PRIME;
			5: return 63'd15;
			default: return 63'(SMALL_P[$urandom_range(15)]);
		endcase
	endfunction

	logic [60:0] ph_start [6] = '{61'd1, 61'd0, N_MAX, 61'd5, 61'd3, 61'd1};
	logic [60:0] ph_end   [6] = '{N_MAX, 61'd5, N_MAX, 61'd8, N_MAX, 61'd1};
	logic [6:0]  ph_use   [6] = '{7'd3, 7'd64, 7'd0, 7'd2, 7'd127, 7'd1};

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		quiet     = 1'b0;
		hold_req  = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		cycles    = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: fill every entry, special moduli at the top of the table
		write_cfg(CFG_START_N, 61'd1);
		write_cfg(CFG_END_N, N_MAX);
		write_cfg(CFG_PRIMES_IN_USE, 61'd3);
		load(6'd0, 63'd5, 63'd4);
		load(6'd1, 63'd7, 63'd6);
		for (int i = 2; i < 59; i++) load(6'(i), 63'(SMALL_P[i % 16]), 63'd1);
		load(6'd59, BIG_PRIME, 63'h7fff_ffff_ffff_ffff);
		load(6'd60, 63'd15, 63'd14);
		load(6'd61, 63'd1, 63'd0);
		load(6'd62, 63'd2, 63'd1);
		load(6'd63, 63'd0, 63'd5);
		repeat (3) step_n();
		load(6'd2, 63'd3, 63'd0);
		step_n();
		drain();
		write_cfg(CFG_PRIMES_IN_USE, 61'd64);
		repeat (2) step_n();
		drain();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(CFG_START_N, ph_start[ph]);
			write_cfg(CFG_END_N, ph_end[ph]);
			write_cfg(CFG_PRIMES_IN_USE, 61'(ph_use[ph]));
			quiet = (ph == 3);
			if (ph == 4) hold_req = 1'b1;
			for (int k = 0; k < 13; k++) begin
				if ($urandom_range(99) < 40) step_n();
				else load(6'($urandom), pick_modulus(), 63'({$urandom, $urandom}));
			end
			drain();
		end

		if (sb.errors == 0)
			$display("** factorial_residue_sieve: PASSED **");
		else
			$display("** factorial_residue_sieve: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
